/* design/qrv_pkg.sv */
// Shared types, constants and tables for the quaternion rotation-vector update.
// No dependencies; every other file of the block imports this package.
package qrv_pkg;

    // Register map
    localparam logic [2:0]  ADDR_SAL      = 3'd0;
    localparam logic [30:0] SAL_RESET     = 31'd268;

    // Fixed-length iteration counts
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 31;
    localparam int DIV_BITS     = 60;

    // pi/2 in Q.30 and the gain-corrected CORDIC start value
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Input transaction
    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } t_quat_in;

    // Result transaction
    typedef struct packed {
        logic signed [31:0] new_w;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               saturated;
    } t_quat_out;

    // Magnitude and reduced half angle
    typedef struct packed {
        t_quat_in    side;
        logic [31:0] mag;
        logic        use_half;
        logic [1:0]  quad;
        logic [30:0] rem;
    } t_angle;

    // Half-angle cosine and sine
    typedef struct packed {
        t_quat_in           side;
        logic [31:0]        mag;
        logic               use_half;
        logic signed [33:0] cosv;
        logic signed [33:0] sinv;
    } t_trig;

    // Cosine and sine-ratio coefficient, coefficient as sign and magnitude
    typedef struct packed {
        t_quat_in           side;
        logic signed [33:0] cosv;
        logic [59:0]        kmag;
        logic               kneg;
    } t_coef;

    // Arctangent of 2^-i in Q.30, truncated
    function automatic logic signed [32:0] atan_q30(input int idx);
        logic signed [32:0] v;
        case (idx)
            0:  v = 33'sd843314856;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043836;
            3:  v = 33'sd133525158;
            4:  v = 33'sd67021686;
            5:  v = 33'sd33543515;
            6:  v = 33'sd16775850;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194282;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048575;
            11: v = 33'sd524287;
            12: v = 33'sd262143;
            13: v = 33'sd131071;
            14: v = 33'sd65535;
            15: v = 33'sd32767;
            16: v = 33'sd16383;
            17: v = 33'sd8191;
            18: v = 33'sd4095;
            19: v = 33'sd2047;
            20: v = 33'sd1023;
            21: v = 33'sd511;
            22: v = 33'sd255;
            23: v = 33'sd127;
            24: v = 33'sd63;
            25: v = 33'sd31;
            26: v = 33'sd15;
            27: v = 33'sd8;
            28: v = 33'sd4;
            29: v = 33'sd2;
            30: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

/* design/quaternion_rotation_vector_update.sv */
// Top level of the quaternion rotation-vector update: register port, pipeline
// and output skid stage. Depends on qrv_pkg, qrv_mag, qrv_cordic, qrv_div, qrv_mix.
//
//   port group   direction  handshake                 payload
//   in           to block   i_in_valid / o_in_ready   i_in_data  (t_quat_in)
//   out          from block o_out_valid / i_out_ready o_out_data (t_quat_out)
//   register     to block   psel, penable, pwrite     paddr, pwdata, prdata
//
// One transaction accepted per cycle while o_in_ready is high; 139 register stages
// (37 magnitude, 32 CORDIC, 62 divider, 7 product stages, plus the output register).
// The divider, one quotient bit per stage, sets the depth. Synchronous active-low
// reset clears all valid bits and loads the small-angle limit with its reset value.
// A stalled output holds one result in the output register and one in the skid
// stage; the pipeline freezes only once the skid stage is full.
module quaternion_rotation_vector_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  qrv_pkg::t_quat_in    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output qrv_pkg::t_quat_out   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import qrv_pkg::*;

    logic [30:0] r_limit;
    logic        w_en;
    logic        w_mag_v, w_trig_v, w_coef_v, w_pipe_v;
    t_angle      w_angle;
    t_trig       w_trig;
    t_coef       w_coef;
    t_quat_out   w_pipe_d;

    logic        r_ov, n_ov;
    t_quat_out   r_od, n_od;
    logic        r_sv, n_sv;
    t_quat_out   r_sd, n_sd;
    logic        w_take;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SAL) ? {1'b0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= SAL_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_SAL) begin
            r_limit <= pwdata[30:0];
        end
    end

    // Pipeline advances while the skid stage is free
    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    qrv_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_limit (r_limit),
        .o_valid (w_mag_v),
        .o_angle (w_angle)
    );

    qrv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mag_v),
        .i_angle (w_angle),
        .o_valid (w_trig_v),
        .o_trig  (w_trig)
    );

    qrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_trig_v),
        .i_trig  (w_trig),
        .o_valid (w_coef_v),
        .o_coef  (w_coef)
    );

    qrv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_coef_v),
        .i_coef  (w_coef),
        .o_valid (w_pipe_v),
        .o_data  (w_pipe_d)
    );

    // Output register and skid stage
    assign w_take = r_ov && i_out_ready;

    always_comb begin
        n_ov = r_ov;
        n_od = r_od;
        n_sv = r_sv;
        n_sd = r_sd;
        if (r_sv) begin
            if (w_take) begin
                n_od = r_sd;
                n_sv = 1'b0;
            end
        end else if (w_pipe_v) begin
            if (!r_ov || w_take) begin
                n_od = w_pipe_d;
                n_ov = 1'b1;
            end else begin
                n_sd = w_pipe_d;
                n_sv = 1'b1;
            end
        end else if (w_take) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

`ifndef NO_ASSERTIONS
    // Skid stage only fills behind a waiting output
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage holds a result while output register is empty");

    // A full skid stage keeps its result until the output is taken
    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_out_ready) |=> (r_sv && $stable(r_sd)))
        else $error("skid stage lost a result under stall");

    // A pipeline result during an output stall lands in the skid stage
    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pipe_v && w_en && r_ov && !i_out_ready) |=> r_sv)
        else $error("pipeline result dropped during output stall");

    // Output empties when taken with nothing behind it
    a_out_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_sv && !w_pipe_v) |=> !r_ov)
        else $error("output result repeated after transfer");
`endif

endmodule

/* design/qrv_mag.sv */
// Rotation-vector magnitude (squares, pipelined integer square root) and
// half-angle quadrant reduction. Depends on qrv_pkg.
module qrv_mag (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  qrv_pkg::t_quat_in i_data,
    input  logic [30:0]      i_limit,
    output logic             o_valid,
    output qrv_pkg::t_angle  o_angle
);
    import qrv_pkg::*;

    typedef struct packed {
        t_quat_in    side;
        logic [31:0] mag;
        logic        use_half;
        logic [1:0]  quad;
        logic [32:0] acc;
    } t_rr;

    logic [31:0] w_abs [3];
    logic        r_v_sq;
    t_quat_in    r_side_sq;
    logic [63:0] r_sq [3];

    logic        r_sv   [SQRT_STEPS+1];
    t_quat_in    r_sside[SQRT_STEPS+1];
    logic [63:0] r_num  [SQRT_STEPS+1];
    logic [63:0] r_res  [SQRT_STEPS+1];

    logic        w_rvin [3];
    t_rr         w_rin  [3];
    logic        r_rv   [3];
    t_rr         r_rr   [3];
    logic [31:0] w_m;

    // Take magnitudes of the rotation components
    assign w_abs[0] = i_data.rot_x[31] ? (~$unsigned(i_data.rot_x) + 32'd1)
                                       : $unsigned(i_data.rot_x);
    assign w_abs[1] = i_data.rot_y[31] ? (~$unsigned(i_data.rot_y) + 32'd1)
                                       : $unsigned(i_data.rot_y);
    assign w_abs[2] = i_data.rot_z[31] ? (~$unsigned(i_data.rot_z) + 32'd1)
                                       : $unsigned(i_data.rot_z);

    // Square each component
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq <= 1'b0;
        end else if (i_en) begin
            r_v_sq <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_sq <= i_data;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= w_abs[k] * w_abs[k];
            end
        end
    end

    // Sum the squares into the root's radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sside[0] <= r_side_sq;
            r_num[0]   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_res[0]   <= '0;
        end
    end

    // One restoring square-root step per stage
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
        logic [63:0] w_trial;
        logic        w_ge;

        assign w_trial = r_res[g] + Bit;
        assign w_ge    = r_num[g] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[g+1] <= r_sv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sside[g+1] <= r_sside[g];
                r_num[g+1]   <= w_ge ? (r_num[g] - w_trial) : r_num[g];
                r_res[g+1]   <= w_ge ? ((r_res[g] >> 1) + Bit) : (r_res[g] >> 1);
            end
        end
    end

    // Form the half angle and the small-angle decision
    assign w_m       = r_res[SQRT_STEPS][31:0];
    assign w_rvin[0] = r_sv[SQRT_STEPS];
    always_comb begin
        w_rin[0].side     = r_sside[SQRT_STEPS];
        w_rin[0].mag      = w_m;
        w_rin[0].use_half = (w_m == 32'd0) || (w_m < {1'b0, i_limit});
        w_rin[0].quad     = 2'd0;
        w_rin[0].acc      = {w_m[31:1], 2'b00};
    end

    for (genvar j = 1; j < 3; j++) begin : g_rr_link
        assign w_rvin[j] = r_rv[j-1];
        assign w_rin[j]  = r_rr[j-1];
    end

    // Subtract 4, 2, then 1 times pi/2 to find the quadrant
    for (genvar j = 0; j < 3; j++) begin : g_reduce
        localparam logic [32:0] Thr = 33'(HALF_PI_Q30 << (2 - j));
        logic w_ge;
        t_rr  w_nxt;

        assign w_ge = w_rin[j].acc >= Thr;

        always_comb begin
            w_nxt      = w_rin[j];
            w_nxt.quad = {w_rin[j].quad[0], w_ge};
            w_nxt.acc  = w_ge ? (w_rin[j].acc - Thr) : w_rin[j].acc;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[j] <= 1'b0;
            end else if (i_en) begin
                r_rv[j] <= w_rvin[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rr[j] <= w_nxt;
            end
        end
    end

    assign o_valid          = r_rv[2];
    assign o_angle.side     = r_rr[2].side;
    assign o_angle.mag      = r_rr[2].mag;
    assign o_angle.use_half = r_rr[2].use_half;
    assign o_angle.quad     = r_rr[2].quad;
    assign o_angle.rem      = r_rr[2].acc[30:0];

endmodule

/* design/qrv_cordic.sv */
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, then the
// quadrant map to half-angle cosine and sine. Depends on qrv_pkg.
module qrv_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  qrv_pkg::t_angle i_angle,
    output logic            o_valid,
    output qrv_pkg::t_trig  o_trig
);
    import qrv_pkg::*;

    typedef struct packed {
        t_quat_in           side;
        logic [31:0]        mag;
        logic               use_half;
        logic [1:0]         quad;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } t_cs;

    logic  w_vin [CORDIC_STEPS];
    t_cs   w_cin [CORDIC_STEPS];
    logic  r_cv  [CORDIC_STEPS];
    t_cs   r_cs  [CORDIC_STEPS];
    t_cs   w_last;
    logic  r_tv;
    t_trig r_trig;

    // Load the start vector
    assign w_vin[0] = i_valid;
    always_comb begin
        w_cin[0].side     = i_angle.side;
        w_cin[0].mag      = i_angle.mag;
        w_cin[0].use_half = i_angle.use_half;
        w_cin[0].quad     = i_angle.quad;
        w_cin[0].x        = CORDIC_GAIN;
        w_cin[0].y        = '0;
        w_cin[0].z        = $signed({2'b00, i_angle.rem});
    end

    for (genvar g = 1; g < CORDIC_STEPS; g++) begin : g_link
        assign w_vin[g] = r_cv[g-1];
        assign w_cin[g] = r_cs[g-1];
    end

    // Rotate towards zero residual angle
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        logic signed [33:0] w_dx;
        logic signed [33:0] w_dy;
        logic signed [32:0] w_at;
        t_cs                w_nxt;

        assign w_dx = w_cin[g].y >>> g;
        assign w_dy = w_cin[g].x >>> g;
        assign w_at = atan_q30(g);

        always_comb begin
            w_nxt = w_cin[g];
            if (!w_cin[g].z[32]) begin
                w_nxt.x = w_cin[g].x - w_dx;
                w_nxt.y = w_cin[g].y + w_dy;
                w_nxt.z = w_cin[g].z - w_at;
            end else begin
                w_nxt.x = w_cin[g].x + w_dx;
                w_nxt.y = w_cin[g].y - w_dy;
                w_nxt.z = w_cin[g].z + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g] <= 1'b0;
            end else if (i_en) begin
                r_cv[g] <= w_vin[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cs[g] <= w_nxt;
            end
        end
    end

    // Map the quadrant onto cosine and sine
    assign w_last = r_cs[CORDIC_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (i_en) begin
            r_tv <= r_cv[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.side     <= w_last.side;
            r_trig.mag      <= w_last.mag;
            r_trig.use_half <= w_last.use_half;
            case (w_last.quad)
                2'd0: begin
                    r_trig.cosv <= w_last.x;
                    r_trig.sinv <= w_last.y;
                end
                2'd1: begin
                    r_trig.cosv <= -w_last.y;
                    r_trig.sinv <= w_last.x;
                end
                2'd2: begin
                    r_trig.cosv <= -w_last.x;
                    r_trig.sinv <= -w_last.y;
                end
                default: begin
                    r_trig.cosv <= w_last.y;
                    r_trig.sinv <= -w_last.x;
                end
            endcase
        end
    end

    assign o_valid = r_tv;
    assign o_trig  = r_trig;

endmodule

/* design/qrv_div.sv */
// Sine-ratio coefficient: pipelined restoring divider of |sin| * 2^28 by the
// magnitude, one quotient bit per stage, then the small-angle select. Depends on qrv_pkg.
module qrv_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qrv_pkg::t_trig i_trig,
    output logic           o_valid,
    output qrv_pkg::t_coef o_coef
);
    import qrv_pkg::*;

    typedef struct packed {
        t_quat_in           side;
        logic signed [33:0] cosv;
        logic [31:0]        mag;
        logic               use_half;
        logic               neg;
        logic [31:0]        rem;
        logic [DIV_BITS-1:0] nq;
    } t_dv;

    logic [33:0] w_sabs;
    logic        r_dvv [DIV_BITS+1];
    t_dv         r_dv  [DIV_BITS+1];
    logic        r_kv;
    t_coef       r_coef;

    // Load the numerator
    assign w_sabs = i_trig.sinv[33] ? $unsigned(-i_trig.sinv) : $unsigned(i_trig.sinv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (i_en) begin
            r_dvv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0].side     <= i_trig.side;
            r_dv[0].cosv     <= i_trig.cosv;
            r_dv[0].mag      <= i_trig.mag;
            r_dv[0].use_half <= i_trig.use_half;
            r_dv[0].neg      <= i_trig.sinv[33];
            r_dv[0].rem      <= '0;
            r_dv[0].nq       <= {w_sabs[31:0], 28'd0};
        end
    end

    // Shift in one numerator bit, subtract the divisor where it fits
    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        logic [32:0] w_trial;
        logic        w_ge;
        t_dv         w_nxt;

        assign w_trial = {r_dv[g].rem, r_dv[g].nq[DIV_BITS-1]};
        assign w_ge    = w_trial >= {1'b0, r_dv[g].mag};

        always_comb begin
            w_nxt     = r_dv[g];
            w_nxt.rem = w_ge ? 32'(w_trial - {1'b0, r_dv[g].mag}) : w_trial[31:0];
            w_nxt.nq  = {r_dv[g].nq[DIV_BITS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[g+1] <= 1'b0;
            end else if (i_en) begin
                r_dvv[g+1] <= r_dvv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g+1] <= w_nxt;
            end
        end
    end

    // Use one half below the small-angle limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= 1'b0;
        end else if (i_en) begin
            r_kv <= r_dvv[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef.side <= r_dv[DIV_BITS].side;
            r_coef.cosv <= r_dv[DIV_BITS].cosv;
            if (r_dv[DIV_BITS].use_half) begin
                r_coef.kmag <= DIV_BITS'(1) << 29;
                r_coef.kneg <= 1'b0;
            end else begin
                r_coef.kmag <= r_dv[DIV_BITS].nq;
                r_coef.kneg <= r_dv[DIV_BITS].neg;
            end
        end
    end

    assign o_valid = r_kv;
    assign o_coef  = r_coef;

endmodule

/* design/qrv_mix.sv */
// Scaled rotation terms and the quaternion product: split wide multiply,
// rounding, sixteen products, two-level sum, round and saturate. Depends on qrv_pkg.
module qrv_mix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  qrv_pkg::t_coef    i_coef,
    output logic              o_valid,
    output qrv_pkg::t_quat_out o_data
);
    import qrv_pkg::*;

    logic [31:0]        w_tabs [3];
    logic               w_tneg [3];

    // Stage 1: partial products of the coefficient and the rotation
    logic               r_v1;
    t_quat_in           r_side1;
    logic signed [33:0] r_cos1;
    logic [61:0]        r_lo [3];
    logic [61:0]        r_hi [3];
    logic               r_sg [3];
    // Stage 2: signed coefficient times rotation
    logic               r_v2;
    t_quat_in           r_side2;
    logic signed [33:0] r_cos2;
    logic signed [60:0] r_kv [3];
    // Stage 3: rounded scaled rotation
    logic               r_v3;
    t_quat_in           r_side3;
    logic signed [33:0] r_cos3;
    logic signed [31:0] r_kt [3];
    // Stage 4: products
    logic               r_v4;
    logic signed [65:0] r_cp [4];
    logic signed [63:0] r_kp [3][4];
    // Stage 5: partial sums
    logic               r_v5;
    logic signed [66:0] r_pa [4];
    logic signed [66:0] r_pb [4];
    // Stage 6: row sums
    logic               r_v6;
    logic signed [66:0] r_acc [4];
    // Stage 7: rounded and saturated result
    logic               r_v7;
    t_quat_out          r_out;

    logic signed [31:0] w_q [4];
    logic signed [65:0] w_cw [4];
    logic signed [66:0] w_fin [4];
    logic signed [31:0] w_res [4];
    logic [3:0]         w_clip;

    // Take the rotation magnitudes and signs
    assign w_tabs[0] = i_coef.side.rot_x[31] ? (~$unsigned(i_coef.side.rot_x) + 32'd1)
                                             : $unsigned(i_coef.side.rot_x);
    assign w_tabs[1] = i_coef.side.rot_y[31] ? (~$unsigned(i_coef.side.rot_y) + 32'd1)
                                             : $unsigned(i_coef.side.rot_y);
    assign w_tabs[2] = i_coef.side.rot_z[31] ? (~$unsigned(i_coef.side.rot_z) + 32'd1)
                                             : $unsigned(i_coef.side.rot_z);
    assign w_tneg[0] = i_coef.side.rot_x[31];
    assign w_tneg[1] = i_coef.side.rot_y[31];
    assign w_tneg[2] = i_coef.side.rot_z[31];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Multiply the coefficient halves by the rotation magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_coef.side;
            r_cos1  <= i_coef.cosv;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= i_coef.kmag[29:0] * w_tabs[k];
                r_hi[k] <= i_coef.kmag[59:30] * w_tabs[k];
                r_sg[k] <= i_coef.kneg ^ w_tneg[k];
            end
        end
    end

    // Join the halves and apply the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= r_side1;
            r_cos2  <= r_cos1;
            for (int k = 0; k < 3; k++) begin
                r_kv[k] <= r_sg[k] ? -$signed(61'({r_hi[k], 30'd0}) + 61'(r_lo[k]))
                                   : $signed(61'({r_hi[k], 30'd0}) + 61'(r_lo[k]));
            end
        end
    end

    // Round the scaled rotation to Q.28
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side3 <= r_side2;
            r_cos3  <= r_cos2;
            for (int k = 0; k < 3; k++) begin
                r_kt[k] <= 32'((r_kv[k] + (61'sd1 <<< 29)) >>> 30);
            end
        end
    end

    // Form the sixteen products
    assign w_q[0] = r_side3.quat_w;
    assign w_q[1] = r_side3.quat_x;
    assign w_q[2] = r_side3.quat_y;
    assign w_q[3] = r_side3.quat_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_cp[j] <= r_cos3 * w_q[j];
                for (int k = 0; k < 3; k++) begin
                    r_kp[k][j] <= r_kt[k] * w_q[j];
                end
            end
        end
    end

    // Round the cosine terms and add in pairs
    for (genvar j = 0; j < 4; j++) begin : g_cw
        assign w_cw[j] = (r_cp[j] + 66'sd2) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa[0] <= 67'(w_cw[0]) - 67'(r_kp[0][1]);
            r_pb[0] <= -67'(r_kp[1][2]) - 67'(r_kp[2][3]);
            r_pa[1] <= 67'(w_cw[1]) + 67'(r_kp[0][0]);
            r_pb[1] <= 67'(r_kp[2][2]) - 67'(r_kp[1][3]);
            r_pa[2] <= 67'(w_cw[2]) + 67'(r_kp[1][0]);
            r_pb[2] <= 67'(r_kp[0][3]) - 67'(r_kp[2][1]);
            r_pa[3] <= 67'(w_cw[3]) + 67'(r_kp[2][0]);
            r_pb[3] <= 67'(r_kp[1][1]) - 67'(r_kp[0][2]);
        end
    end

    // Complete each row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_acc[j] <= r_pa[j] + r_pb[j];
            end
        end
    end

    // Round to Q.30 and clip to the 32-bit range
    for (genvar j = 0; j < 4; j++) begin : g_fin
        assign w_fin[j] = (r_acc[j] + (67'sd1 <<< 27)) >>> 28;
        always_comb begin
            if (w_fin[j] > 67'sd2147483647) begin
                w_res[j]  = 32'sh7FFFFFFF;
                w_clip[j] = 1'b1;
            end else if (w_fin[j] < -67'sd2147483648) begin
                w_res[j]  = 32'sh80000000;
                w_clip[j] = 1'b1;
            end else begin
                w_res[j]  = w_fin[j][31:0];
                w_clip[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.new_w     <= w_res[0];
            r_out.new_x     <= w_res[1];
            r_out.new_y     <= w_res[2];
            r_out.new_z     <= w_res[3];
            r_out.saturated <= |w_clip;
        end
    end

    assign o_valid = r_v7;
    assign o_data  = r_out;

endmodule
